FILE: hw/rtl/sch_pkg.sv
`default_nettype none
package sch_pkg;

  // Store depth and the widths that follow from it.
  localparam int MAX_POINTS = 256;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int SUM_W = 2 * IDX_W + 18;
  localparam int N2_W = 2 * IDX_W + 4;

  // Fixed widths of the coordinate arithmetic.
  localparam int COORD_W = 16;
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W = 2 * COORD_W;
  localparam int DIST_W = COORD_W + 1;

  // Histogram geometry.
  localparam int NUM_SECTORS = 12;
  localparam int NUM_RINGS = 5;
  localparam int NUM_BINS = NUM_SECTORS * NUM_RINGS;
  localparam int BIN_W = $clog2(NUM_BINS);

  // Operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DESCRIBE = 1'b1;

  // Sectors of the special directions.
  localparam logic [3:0] SECT_COINCIDENT = 4'd6;
  localparam logic [3:0] SECT_NEG_AXIS = 4'd11;

  typedef struct packed {
    logic        opcode;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        start_new;
    logic [7:0]  point_index;
  } sch_req_t;

  typedef struct packed {
    logic [7:0] bin_count;
    logic [3:0] angle_bin;
    logic [2:0] radius_bin;
    logic       index_error;
    logic       last;
  } sch_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/shape_context_histogram.sv
`default_nettype none
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+--------------------------------
// request   | start_i, busy_o, req_i         | taken when start_i && !busy_o
// result    | res_valid_o, res_o             | one-cycle strobe, no back pressure
//
// A load request handles each point already stored in turn: each stored
// point goes through the shared 20x20 multiplier twice and through a
// bit-serial square root of 17 bits. A describe request clears the 60 histogram
// bins, then, for a valid index, handles each other stored point, then streams
// the 60 results. A load into a full store without start_new completes at once.
// Reset clears the point count and the distance sum; the point store has no
// reset. Results cannot be stalled.
module shape_context_histogram
  import sch_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output logic          busy_o,
  input  wire sch_req_t req_i,
  output logic          res_valid_o,
  output sch_res_t      res_o
);

  localparam int MUL_W = (N2_W > DIST_W) ? N2_W : DIST_W;
  localparam int LHS_W = DIST_W + N2_W;
  localparam int CMP_W = (LHS_W > SUM_W + 4) ? LHS_W : SUM_W + 4;
  localparam int XW = (CNT_W > 8) ? CNT_W : 8;
  localparam int RV_W = 2 * DIST_W;
  localparam int REM_W = DIST_W + 3;

  typedef enum logic [20:0] {
    S_IDLE  = 21'd1 << 0,
    S_CLR   = 21'd1 << 1,
    S_NSQ   = 21'd1 << 2,
    S_REF   = 21'd1 << 3,
    S_REFW  = 21'd1 << 4,
    S_CHK   = 21'd1 << 5,
    S_RD    = 21'd1 << 6,
    S_DIFF  = 21'd1 << 7,
    S_SQX   = 21'd1 << 8,
    S_SQY   = 21'd1 << 9,
    S_SUM   = 21'd1 << 10,
    S_SQRT  = 21'd1 << 11,
    S_ACC   = 21'd1 << 12,
    S_SCALE = 21'd1 << 13,
    S_RING  = 21'd1 << 14,
    S_SECT  = 21'd1 << 15,
    S_HRD   = 21'd1 << 16,
    S_HWR   = 21'd1 << 17,
    S_NEXT  = 21'd1 << 18,
    S_FIN   = 21'd1 << 19,
    S_EMIT  = 21'd1 << 20
  } state_e;

  state_e state_q, state_d;

  // Control registers.
  logic [CNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [BIN_W-1:0] clr_q, clr_d;
  logic [4:0]       it_q, it_d;
  logic [2:0]       ring_q, ring_d;
  logic [3:0]       ea_q, ea_d;
  logic [2:0]       er_q, er_d;
  logic             desc_q, desc_d;
  logic             err_q, err_d;
  logic             drain_q, drain_d;
  logic             res_valid_q, res_valid_d;

  // Datapath registers.
  logic [COORD_W-1:0]       ref_x_q, ref_x_d, ref_y_q, ref_y_d;
  logic [7:0]               idx_q, idx_d;
  logic signed [DIFF_W-1:0] u_q, u_d, v_q, v_d;
  logic [COORD_W-1:0]       ax_q, ax_d, ay_q, ay_d;
  logic [SQ_W-1:0]          sqx_q, sqx_d, sqy_q, sqy_d;
  logic [RV_W-1:0]          rv_q, rv_d;
  logic [REM_W-1:0]         rem_q, rem_d;
  logic [DIST_W-1:0]        root_q, root_d;
  logic [N2_W-1:0]          n2x8_q, n2x8_d;
  logic [LHS_W-1:0]         lhs_q, lhs_d;
  logic [BIN_W-1:0]         bin_q, bin_d;
  logic [3:0]               oa_q, oa_d;
  logic [2:0]               or_q, or_d;
  logic                     olast_q, olast_d;

  // Point store and histogram memory.
  logic [COORD_W-1:0] store_x [MAX_POINTS];
  logic [COORD_W-1:0] store_y [MAX_POINTS];
  logic [COORD_W-1:0] rd_x_q, rd_y_q;
  logic [IDX_W-1:0]   st_raddr;
  logic               st_we;
  logic [7:0]         hist [NUM_BINS];
  logic [7:0]         hrd_q;
  logic               h_we;
  logic [BIN_W-1:0]   h_waddr, h_raddr;
  logic [7:0]         h_wdata;

  logic                 accept;
  logic [XW-1:0]        idx_ext;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [2*MUL_W-1:0]   prod;
  logic [REM_W-1:0]     rem_sh, trial;
  logic [CMP_W-1:0]     cmp_rhs;
  logic [3:0]           sector;
  logic [SQ_W-1:0]      a2, b2;
  logic [1:0]           quad;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign idx_ext = XW'(idx_q);

  // Shared multiplier with operands chosen by the sequencer.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_NSQ: begin
        mul_a = MUL_W'(count_q);
        mul_b = MUL_W'(count_q);
      end
      S_SQX: begin
        mul_a = MUL_W'(ax_q);
        mul_b = MUL_W'(ax_q);
      end
      S_SQY: begin
        mul_a = MUL_W'(ay_q);
        mul_b = MUL_W'(ay_q);
      end
      S_SCALE: begin
        mul_a = MUL_W'(root_q);
        mul_b = MUL_W'(n2x8_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // One square root digit per cycle.
  assign rem_sh = {rem_q[REM_W-3:0], rv_q[RV_W-1 -: 2]};
  assign trial = REM_W'({root_q, 2'b01});

  // Ring edge for the current ring.
  assign cmp_rhs = CMP_W'(sum_q) << ring_q;

  // Sector of the direction (u, v), with u = -dx and v = -dy.
  always_comb begin
    if (!u_q[DIFF_W-1] && (u_q != 0) && !v_q[DIFF_W-1]) begin
      quad = 2'd0;
    end else if (((u_q == 0) || u_q[DIFF_W-1]) && !v_q[DIFF_W-1] && (v_q != 0)) begin
      quad = 2'd1;
    end else if (u_q[DIFF_W-1] && (v_q[DIFF_W-1] || (v_q == 0))) begin
      quad = 2'd2;
    end else begin
      quad = 2'd3;
    end
    a2 = quad[0] ? sqy_q : sqx_q;
    b2 = quad[0] ? sqx_q : sqy_q;
    if ((u_q == 0) && (v_q == 0)) begin
      sector = SECT_COINCIDENT;
    end else if ((v_q == 0) && !u_q[DIFF_W-1]) begin
      sector = SECT_NEG_AXIS;
    end else if ((SQ_W + 2)'(b2) * 3 < (SQ_W + 2)'(a2)) begin
      sector = 4'(quad) * 4'd3;
    end else if ((SQ_W + 2)'(b2) < (SQ_W + 2)'(a2) * 3) begin
      sector = 4'(quad) * 4'd3 + 4'd1;
    end else begin
      sector = 4'(quad) * 4'd3 + 4'd2;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    sum_d = sum_q;
    j_d = j_q;
    clr_d = clr_q;
    it_d = it_q;
    ring_d = ring_q;
    ea_d = ea_q;
    er_d = er_q;
    desc_d = desc_q;
    err_d = err_q;
    drain_d = 1'b0;
    res_valid_d = 1'b0;
    ref_x_d = ref_x_q;
    ref_y_d = ref_y_q;
    idx_d = idx_q;
    u_d = u_q;
    v_d = v_q;
    ax_d = ax_q;
    ay_d = ay_q;
    sqx_d = sqx_q;
    sqy_d = sqy_q;
    rv_d = rv_q;
    rem_d = rem_q;
    root_d = root_q;
    n2x8_d = n2x8_q;
    lhs_d = lhs_q;
    bin_d = bin_q;
    oa_d = oa_q;
    or_d = or_q;
    olast_d = olast_q;
    st_raddr = j_q[IDX_W-1:0];
    st_we = 1'b0;
    h_we = 1'b0;
    h_waddr = bin_q;
    h_wdata = (hrd_q == 8'hFF) ? hrd_q : hrd_q + 8'd1;
    h_raddr = bin_q;

    // The last result goes out in the cycle after its read.
    if (drain_q) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          desc_d = req_i.opcode;
          idx_d = req_i.point_index;
          ref_x_d = req_i.point_x;
          ref_y_d = req_i.point_y;
          j_d = '0;
          clr_d = '0;
          ea_d = '0;
          er_d = '0;
          if (req_i.opcode == OP_DESCRIBE) begin
            err_d = XW'(req_i.point_index) >= XW'(count_q);
            state_d = S_CLR;
          end else if (req_i.start_new) begin
            count_d = '0;
            sum_d = '0;
            state_d = S_CHK;
          end else if (count_q != CNT_W'(MAX_POINTS)) begin
            state_d = S_CHK;
          end
        end
      end
      S_CLR: begin
        h_we = 1'b1;
        h_waddr = clr_q;
        h_wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == BIN_W'(NUM_BINS - 1)) begin
          state_d = err_q ? S_EMIT : S_NSQ;
        end
      end
      S_NSQ: begin
        n2x8_d = N2_W'({prod, 3'b000});
        state_d = S_REF;
      end
      S_REF: begin
        st_raddr = idx_ext[IDX_W-1:0];
        state_d = S_REFW;
      end
      S_REFW: begin
        ref_x_d = rd_x_q;
        ref_y_d = rd_y_q;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (j_q >= count_q) begin
          state_d = desc_q ? S_EMIT : S_FIN;
        end else if (desc_q && (XW'(j_q) == idx_ext)) begin
          j_d = j_q + 1'b1;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_DIFF;
      end
      S_DIFF: begin
        u_d = $signed({1'b0, ref_x_q}) - $signed({1'b0, rd_x_q});
        v_d = $signed({1'b0, ref_y_q}) - $signed({1'b0, rd_y_q});
        ax_d = u_d[DIFF_W-1] ? COORD_W'(-u_d) : u_d[COORD_W-1:0];
        ay_d = v_d[DIFF_W-1] ? COORD_W'(-v_d) : v_d[COORD_W-1:0];
        state_d = S_SQX;
      end
      S_SQX: begin
        sqx_d = SQ_W'(prod);
        state_d = S_SQY;
      end
      S_SQY: begin
        sqy_d = SQ_W'(prod);
        state_d = S_SUM;
      end
      S_SUM: begin
        rv_d = RV_W'(sqx_q) + RV_W'(sqy_q);
        rem_d = '0;
        root_d = '0;
        it_d = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        rv_d = {rv_q[RV_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d = rem_sh - trial;
          root_d = {root_q[DIST_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          root_d = {root_q[DIST_W-2:0], 1'b0};
        end
        it_d = it_q + 1'b1;
        if (it_q == 5'(DIST_W - 1)) begin
          state_d = desc_q ? S_SCALE : S_ACC;
        end
      end
      S_ACC: begin
        sum_d = sum_q + SUM_W'({root_q, 1'b0});
        state_d = S_NEXT;
      end
      S_SCALE: begin
        lhs_d = LHS_W'(prod);
        ring_d = '0;
        state_d = S_RING;
      end
      S_RING: begin
        if (CMP_W'(lhs_q) < cmp_rhs) begin
          state_d = S_SECT;
        end else if (ring_q == 3'(NUM_RINGS - 1)) begin
          state_d = S_NEXT;
        end else begin
          ring_d = ring_q + 1'b1;
        end
      end
      S_SECT: begin
        bin_d = BIN_W'({ring_q, 3'b000}) + BIN_W'({ring_q, 2'b00}) + BIN_W'(sector);
        state_d = S_HRD;
      end
      S_HRD: begin
        state_d = S_HWR;
      end
      S_HWR: begin
        h_we = 1'b1;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        j_d = j_q + 1'b1;
        state_d = S_CHK;
      end
      S_FIN: begin
        st_we = 1'b1;
        count_d = count_q + 1'b1;
        state_d = S_IDLE;
      end
      S_EMIT: begin
        h_raddr = BIN_W'({er_q, 3'b000}) + BIN_W'({er_q, 2'b00}) + BIN_W'(ea_q);
        res_valid_d = 1'b1;
        oa_d = ea_q;
        or_d = er_q;
        olast_d = (er_q == 3'(NUM_RINGS - 1)) && (ea_q == 4'(NUM_SECTORS - 1));
        if (ea_q == 4'(NUM_SECTORS - 1)) begin
          ea_d = '0;
          er_d = er_q + 1'b1;
        end else begin
          ea_d = ea_q + 1'b1;
        end
        if (olast_d) begin
          drain_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      sum_q <= '0;
      j_q <= '0;
      clr_q <= '0;
      it_q <= '0;
      ring_q <= '0;
      ea_q <= '0;
      er_q <= '0;
      desc_q <= 1'b0;
      err_q <= 1'b0;
      drain_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q <= sum_d;
      j_q <= j_d;
      clr_q <= clr_d;
      it_q <= it_d;
      ring_q <= ring_d;
      ea_q <= ea_d;
      er_q <= er_d;
      desc_q <= desc_d;
      err_q <= err_d;
      drain_q <= drain_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    ref_x_q <= ref_x_d;
    ref_y_q <= ref_y_d;
    idx_q <= idx_d;
    u_q <= u_d;
    v_q <= v_d;
    ax_q <= ax_d;
    ay_q <= ay_d;
    sqx_q <= sqx_d;
    sqy_q <= sqy_d;
    rv_q <= rv_d;
    rem_q <= rem_d;
    root_q <= root_d;
    n2x8_q <= n2x8_d;
    lhs_q <= lhs_d;
    bin_q <= bin_d;
    oa_q <= oa_d;
    or_q <= or_d;
    olast_q <= olast_d;
  end

  // Point store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_x[count_q[IDX_W-1:0]] <= ref_x_q;
      store_y[count_q[IDX_W-1:0]] <= ref_y_q;
    end
    rd_x_q <= store_x[st_raddr];
    rd_y_q <= store_y[st_raddr];
  end

  // Histogram: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hist[h_waddr] <= h_wdata;
    end
    hrd_q <= hist[h_raddr];
  end

  assign res_valid_o = res_valid_q;
  assign res_o = '{
    bin_count:   err_q ? 8'd0 : hrd_q,
    angle_bin:   oa_q,
    radius_bin:  or_q,
    index_error: err_q,
    last:        olast_q && res_valid_q
  };

`ifndef SYNTHESIS
  // Results only stream out of a describe request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy_o && desc_q)
    else $error("result strobe outside a describe request");

  // The final result closes the stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o)
    else $error("result strobe after the last result");

  // The point count never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  // A request is only taken while idle; a describe request then turns the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.opcode == OP_DESCRIBE |=> busy_o)
    else $error("describe request did not start");
`endif

endmodule
`default_nettype wire
